// ----- hw/rtl/bia_pkg.sv -----
// bia_pkg: shared constants for the batch index allocator.
// Field widths, mode codes and result status codes.
// No dependencies.
package bia_pkg;

	// Fixed field widths
	localparam int MODE_W   = 2;
	localparam int COUNT_W  = 4;
	localparam int STATUS_W = 2;

	// Cap value after reset (saturated to the pool size where smaller)
	localparam int MAX_NODES_RESET = 4096;

	// Input item kinds
	localparam logic [MODE_W-1:0] MODE_ALLOC = 2'd0;
	localparam logic [MODE_W-1:0] MODE_FREE  = 2'd1;
	localparam logic [MODE_W-1:0] MODE_CHECK = 2'd2;

	// Result status codes
	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NO_MEM = 2'd1;
	localparam logic [STATUS_W-1:0] ST_REJECT = 2'd2;

endpackage

// ----- hw/rtl/batch_index_allocator.sv -----
// Batch index allocator. Free and check items: result registered on acceptance, or held
// until the output is free; a batch allocate of n indices pops and bumps one per cycle,
// then sends one result per cycle from the batch buffer while the receiver is ready; a
// failed allocate pushes back one index per cycle, then one result. Items are accepted
// only while the sequencer is idle. Reset clears the stack pointer and bump count and sets
// the cap to 4096 (or the pool size where smaller); the stack memory is not cleared.
module batch_index_allocator #(
	parameter int INDEX_BITS = 12,
	parameter int MAX_BATCH  = 8
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	// configuration: max_nodes
	input  logic                                          cfg_valid,
	output logic                                          cfg_ready,
	input  logic [INDEX_BITS:0]                           cfg_data,
	// input items
	input  logic                                          s_tvalid,
	output logic                                          s_tready,
	input  logic [((bia_pkg::COUNT_W+INDEX_BITS+7)/8)*8-1:0] s_tdata,  // batch_count, node_in
	input  logic [bia_pkg::MODE_W-1:0]                    s_tuser,  // mode
	// result items
	output logic                                          m_tvalid,
	input  logic                                          m_tready,
	output logic [((INDEX_BITS+1+7)/8)*8-1:0]             m_tdata,  // node_out, is_valid
	output logic [bia_pkg::STATUS_W-1:0]                  m_tuser,  // status
	output logic                                          m_tlast
);
	import bia_pkg::*;

	localparam int M_TDATA_W   = ((INDEX_BITS + 1 + 7) / 8) * 8;
	localparam int POOL_SIZE   = 1 << INDEX_BITS;
	localparam int RESET_CAP_I = (MAX_NODES_RESET < POOL_SIZE) ? MAX_NODES_RESET : POOL_SIZE;
	localparam int CAP_ROUND   = RESET_CAP_I;
	localparam logic [INDEX_BITS:0] RESET_CAP = CAP_ROUND[INDEX_BITS:0];
	localparam logic [INDEX_BITS:0] POOL_CAP  = {1'b1, {INDEX_BITS{1'b0}}};

	logic [INDEX_BITS:0]   limit_q;
	logic                  mem_we;
	logic [INDEX_BITS-1:0] mem_waddr;
	logic [INDEX_BITS-1:0] mem_wdata;
	logic                  mem_re;
	logic [INDEX_BITS-1:0] mem_raddr;
	logic [INDEX_BITS-1:0] mem_rdata;
	logic [INDEX_BITS-1:0] node_out;
	logic                  is_valid;

	// Cap register, saturated to the pool size on write
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= RESET_CAP;
		end else if (cfg_valid && cfg_ready) begin
			limit_q <= (cfg_data > POOL_CAP) ? POOL_CAP : cfg_data;
		end
	end

	bia_stack_ram #(
		.ADDR_W (INDEX_BITS),
		.DATA_W (INDEX_BITS)
	) u_stack (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	bia_seq #(
		.INDEX_BITS (INDEX_BITS),
		.MAX_BATCH  (MAX_BATCH)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_mode      (s_tuser),
		.in_count     (s_tdata[COUNT_W-1:0]),
		.in_node      (s_tdata[COUNT_W +: INDEX_BITS]),
		.limit        (limit_q),
		.mem_we       (mem_we),
		.mem_waddr    (mem_waddr),
		.mem_wdata    (mem_wdata),
		.mem_re       (mem_re),
		.mem_raddr    (mem_raddr),
		.mem_rdata    (mem_rdata),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_node     (node_out),
		.out_status   (m_tuser),
		.out_is_valid (is_valid),
		.out_last     (m_tlast)
	);

	// Result packing, zero-filled to whole bytes
	assign m_tdata = M_TDATA_W'({is_valid, node_out});

endmodule

// ----- hw/rtl/bia_stack_ram.sv -----
// bia_stack_ram: free-index stack storage, one write and one read port.
// Synchronous registered read, contents not reset.
// No dependencies.
module bia_stack_ram #(
	parameter int ADDR_W = 12,
	parameter int DATA_W = 12
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [(1 << ADDR_W)];
	logic [DATA_W-1:0] rdata_q;

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/bia_seq.sv -----
// bia_seq: allocation sequencer. Owns the stack pointer, the bump count,
// the batch buffer and the result register; drives the stack memory.
// Depends on bia_pkg.
module bia_seq #(
	parameter int INDEX_BITS = 12,
	parameter int MAX_BATCH  = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// item input
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [bia_pkg::MODE_W-1:0]     in_mode,
	input  logic [bia_pkg::COUNT_W-1:0]    in_count,
	input  logic [INDEX_BITS-1:0]          in_node,
	// effective cap, already saturated to the pool size
	input  logic [INDEX_BITS:0]            limit,
	// stack memory port
	output logic                           mem_we,
	output logic [INDEX_BITS-1:0]          mem_waddr,
	output logic [INDEX_BITS-1:0]          mem_wdata,
	output logic                           mem_re,
	output logic [INDEX_BITS-1:0]          mem_raddr,
	input  logic [INDEX_BITS-1:0]          mem_rdata,
	// result output
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [INDEX_BITS-1:0]          out_node,
	output logic [bia_pkg::STATUS_W-1:0]   out_status,
	output logic                           out_is_valid,
	output logic                           out_last
);
	import bia_pkg::*;

	localparam int CNT_W = $clog2(MAX_BATCH + 1);
	localparam int TK_AW = (MAX_BATCH > 1) ? $clog2(MAX_BATCH) : 1;

	// Sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_POP  = 3'd1;
	localparam logic [2:0] S_BUMP = 3'd2;
	localparam logic [2:0] S_BACK = 3'd3;
	localparam logic [2:0] S_EMIT = 3'd4;
	localparam logic [2:0] S_RESP = 3'd5;

	logic [2:0]            state_q;
	logic [INDEX_BITS:0]   depth_q;
	logic [INDEX_BITS:0]   issued_q;
	logic [CNT_W-1:0]      want_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [CNT_W-1:0]      rd_cnt_q;
	logic                  pop_pend_s1;
	logic [TK_AW-1:0]      pop_idx_s1;
	logic                  tk_rd_valid_s1;
	logic [CNT_W-1:0]      tk_rd_idx_s1;
	logic [INDEX_BITS-1:0] tk_rdata_s1;
	logic [INDEX_BITS-1:0] taken_mem [MAX_BATCH];
	logic [STATUS_W-1:0]   resp_status_q;
	logic                  resp_isv_q;
	logic                  out_valid_q;
	logic [INDEX_BITS-1:0] out_node_q;
	logic [STATUS_W-1:0]   out_status_q;
	logic                  out_isv_q;
	logic                  out_last_q;

	logic                  accept;
	logic                  out_free;
	logic                  is_free;
	logic                  is_check;
	logic [INDEX_BITS:0]   node_ext;
	logic                  node_issued;
	logic                  free_reject;
	logic [STATUS_W-1:0]   acc_status;
	logic                  acc_isv;
	logic                  direct_resp;
	logic [31:0]           bc_ext;
	logic [CNT_W-1:0]      n_sat;
	logic [INDEX_BITS:0]   depth_m1;
	logic                  pop_fire;
	logic                  bump_fire;
	logic                  tk_more;
	logic                  tk_load;
	logic                  tk_issue;
	logic                  tk_last;
	logic                  free_push;
	logic                  back_push;
	logic                  resp_load;
	logic                  out_load;
	logic                  tk_we;
	logic [TK_AW-1:0]      tk_waddr;
	logic [INDEX_BITS-1:0] tk_wdata;
	logic [STATUS_W-1:0]   out_status_d;
	logic                  out_isv_d;

	// Input decode and single-result checks
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_free    = !out_valid_q || out_ready;
	assign is_free     = accept && (in_mode == MODE_FREE);
	assign is_check    = accept && (in_mode == MODE_CHECK);
	assign node_ext    = {1'b0, in_node};
	assign node_issued = (node_ext < issued_q);
	assign free_reject = !node_issued || (depth_q >= issued_q);
	assign acc_status  = (is_free && free_reject) ? ST_REJECT : ST_OK;
	assign acc_isv     = is_check && node_issued;
	assign direct_resp = (is_free || is_check) && out_free;

	// Batch size, saturated to the buffer depth
	assign bc_ext = 32'(in_count);
	assign n_sat  = (bc_ext > 32'(MAX_BATCH)) ? CNT_W'(MAX_BATCH) : CNT_W'(bc_ext);

	// Pop from the stack one entry a cycle, then bump
	assign depth_m1  = depth_q - 1'b1;
	assign pop_fire  = (state_q == S_POP) && (depth_q != '0) && (cnt_q < want_q);
	assign bump_fire = (state_q == S_BUMP) && !pop_pend_s1 && (cnt_q != want_q)
		&& (issued_q < limit);

	// Batch buffer readout for results or rollback
	assign tk_more  = (state_q == S_BACK) ? (rd_cnt_q < cnt_q) : (rd_cnt_q < want_q);
	assign tk_load  = (state_q == S_EMIT) && tk_rd_valid_s1 && out_free;
	assign tk_issue = ((state_q == S_BACK) && tk_more)
		|| ((state_q == S_EMIT) && tk_more && (!tk_rd_valid_s1 || tk_load));
	assign tk_last  = (tk_rd_idx_s1 == want_q - CNT_W'(1));

	// Stack pushes; reads and writes never share a cycle
	assign free_push = is_free && !free_reject && !depth_q[INDEX_BITS];
	assign back_push = (state_q == S_BACK) && tk_rd_valid_s1 && !depth_q[INDEX_BITS];
	assign mem_we    = free_push || back_push;
	assign mem_waddr = depth_q[INDEX_BITS-1:0];
	assign mem_wdata = free_push ? in_node : tk_rdata_s1;
	assign mem_re    = pop_fire;
	assign mem_raddr = depth_m1[INDEX_BITS-1:0];

	// Batch buffer write: popped data lands in the cycle after the pop and wins
	assign tk_we    = pop_pend_s1 || bump_fire;
	assign tk_waddr = pop_pend_s1 ? pop_idx_s1 : cnt_q[TK_AW-1:0];
	assign tk_wdata = pop_pend_s1 ? mem_rdata : issued_q[INDEX_BITS-1:0];

	// Result register load
	assign resp_load = (state_q == S_RESP) && out_free;
	assign out_load  = direct_resp || tk_load || resp_load;

	always_comb begin
		if (direct_resp) begin
			out_status_d = acc_status;
			out_isv_d    = acc_isv;
		end else if (tk_load) begin
			out_status_d = ST_OK;
			out_isv_d    = 1'b0;
		end else begin
			out_status_d = resp_status_q;
			out_isv_d    = resp_isv_q;
		end
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= S_IDLE;
			depth_q        <= '0;
			issued_q       <= '0;
			want_q         <= '0;
			cnt_q          <= '0;
			rd_cnt_q       <= '0;
			pop_pend_s1    <= 1'b0;
			tk_rd_valid_s1 <= 1'b0;
			out_valid_q    <= 1'b0;
		end else begin
			if (mem_we) begin
				depth_q <= depth_q + 1'b1;
			end else if (pop_fire) begin
				depth_q <= depth_m1;
			end
			if (bump_fire) begin
				issued_q <= issued_q + 1'b1;
			end
			if (pop_fire || bump_fire) begin
				cnt_q <= cnt_q + 1'b1;
			end
			pop_pend_s1 <= pop_fire;

			if (tk_issue) begin
				rd_cnt_q       <= rd_cnt_q + 1'b1;
				tk_rd_valid_s1 <= 1'b1;
			end else if ((state_q == S_BACK) || tk_load) begin
				tk_rd_valid_s1 <= 1'b0;
			end

			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (in_mode) inside
							MODE_ALLOC: begin
								if (n_sat != '0) begin
									want_q  <= n_sat;
									cnt_q   <= '0;
									state_q <= S_POP;
								end
							end
							MODE_FREE, MODE_CHECK: begin
								if (!out_free) begin
									state_q <= S_RESP;
								end
							end
							default: ;
						endcase
					end
				end
				S_POP: begin
					if (!pop_fire) begin
						state_q <= S_BUMP;
					end
				end
				S_BUMP: begin
					if (!pop_pend_s1) begin
						if (cnt_q == want_q) begin
							rd_cnt_q <= '0;
							state_q  <= S_EMIT;
						end else if (issued_q >= limit) begin
							rd_cnt_q <= '0;
							state_q  <= S_BACK;
						end
					end
				end
				S_BACK: begin
					if (!tk_more && !tk_rd_valid_s1) begin
						state_q <= S_RESP;
					end
				end
				S_EMIT: begin
					if (tk_load && tk_last) begin
						state_q <= S_IDLE;
					end
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Batch buffer memory and datapath registers
	always_ff @(posedge clk) begin
		if (tk_we) begin
			taken_mem[tk_waddr] <= tk_wdata;
		end
		if (tk_issue) begin
			tk_rdata_s1  <= taken_mem[rd_cnt_q[TK_AW-1:0]];
			tk_rd_idx_s1 <= rd_cnt_q;
		end
		if (pop_fire) begin
			pop_idx_s1 <= cnt_q[TK_AW-1:0];
		end
		// pending single result: free/check response or allocation failure
		if (accept) begin
			resp_status_q <= acc_status;
			resp_isv_q    <= acc_isv;
		end else if (state_q == S_BACK) begin
			resp_status_q <= ST_NO_MEM;
			resp_isv_q    <= 1'b0;
		end
		if (out_load) begin
			out_node_q   <= tk_load ? tk_rdata_s1 : '0;
			out_status_q <= out_status_d;
			out_isv_q    <= out_isv_d;
			out_last_q   <= tk_load ? tk_last : 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_node     = out_node_q;
	assign out_status   = out_status_q;
	assign out_is_valid = out_isv_q;
	assign out_last     = out_last_q;

endmodule

// ----- dv/tb_batch_index_allocator.sv -----
// Self-checking testbench for batch_index_allocator: a directed table, then random
// allocate/free/check traffic over several cap settings, checked against a local model.
// Depends on bia_pkg and the batch_index_allocator RTL.
`timescale 1ns / 100ps

module tb_batch_index_allocator;
	import bia_pkg::*;

	localparam int INDEX_BITS = 12;
	localparam int MAX_BATCH  = 8;
	localparam int POOL       = 1 << INDEX_BITS;
	localparam int TAIL       = 4 * MAX_BATCH + 8;  // settle time after last result
	localparam int STALL_LIMIT = 4000;             // cycles with no transfer at all
	localparam int HOLD_CYCLES = 300;              // long receiver hold-off
	localparam int RAND_PER_PHASE = 19;
	localparam int N_PHASES = 6;
	localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;  // unused mode, ignored by the block

	typedef struct packed {
		logic [INDEX_BITS-1:0] node;
		logic [STATUS_W-1:0]   status;
		logic                  valid;
		logic                  last;
	} grant_t;

	typedef struct packed {
		logic [MODE_W-1:0]     mode;
		logic [COUNT_W-1:0]    cnt;
		logic [INDEX_BITS-1:0] node;
		logic                  typed;   // expected result written below, single result
		logic [INDEX_BITS-1:0] t_node;
		logic [STATUS_W-1:0]   t_status;
		logic                  t_valid;
	} req_row_t;

	localparam int DIR_N = 17;
	req_row_t dir_rows [DIR_N] = '{
		// after reset: nothing issued yet
		'{MODE_CHECK, 4'd0,  12'd0,    1'b1, 12'd0, ST_OK,     1'b0},
		'{MODE_FREE,  4'd0,  12'd0,    1'b1, 12'd0, ST_REJECT, 1'b0},
		'{MODE_ALLOC, 4'd1,  12'd0,    1'b1, 12'd0, ST_OK,     1'b0},
		// ignored items
		'{MODE_NONE,  4'd0,  12'd4095, 1'b0, 12'd0, ST_OK,     1'b0},
		'{MODE_ALLOC, 4'd0,  12'd4095, 1'b0, 12'd0, ST_OK,     1'b0},
		// full batch, then oversized batch that saturates
		'{MODE_ALLOC, 4'd8,  12'd0,    1'b0, 12'd0, ST_OK,     1'b0},
		'{MODE_ALLOC, 4'd15, 12'd0,    1'b0, 12'd0, ST_OK,     1'b0},
		// validity around the issued count and at the top of the range
		'{MODE_CHECK, 4'd0,  12'd16,   1'b1, 12'd0, ST_OK,     1'b1},
		'{MODE_CHECK, 4'd15, 12'd17,   1'b1, 12'd0, ST_OK,     1'b0},
		'{MODE_CHECK, 4'd0,  12'd4095, 1'b1, 12'd0, ST_OK,     1'b0},
		'{MODE_FREE,  4'd15, 12'd4095, 1'b1, 12'd0, ST_REJECT, 1'b0},
		// accepted free, then the same index again (not detected)
		'{MODE_FREE,  4'd0,  12'd3,    1'b1, 12'd0, ST_OK,     1'b0},
		'{MODE_FREE,  4'd0,  12'd3,    1'b1, 12'd0, ST_OK,     1'b0},
		'{MODE_FREE,  4'd0,  12'd16,   1'b1, 12'd0, ST_OK,     1'b0},
		// pops from the stack, then a mix of pops and bumps
		'{MODE_ALLOC, 4'd2,  12'd0,    1'b0, 12'd0, ST_OK,     1'b0},
		'{MODE_ALLOC, 4'd9,  12'd0,    1'b0, 12'd0, ST_OK,     1'b0},
		'{MODE_ALLOC, 4'd1,  12'd0,    1'b0, 12'd0, ST_OK,     1'b0}
	};

	logic [INDEX_BITS:0] phase_caps [N_PHASES] = '{
		13'd8191, 13'd40, 13'd0, 13'd1, 13'd4096, 13'd60
	};

	// DUT signals
	logic                  clk;
	logic                  arst_n;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [INDEX_BITS:0]   cfg_data;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [15:0]           s_tdata;   // batch_count, node_in
	logic [MODE_W-1:0]     s_tuser;   // mode
	logic                  m_tvalid;
	logic                  m_tready;
	logic [15:0]           m_tdata;   // node_out, is_valid, pad
	logic [STATUS_W-1:0]   m_tuser;   // status
	logic                  m_tlast;

	// Model state
	logic [INDEX_BITS-1:0] free_lifo [POOL];
	logic [INDEX_BITS:0]   lifo_depth;
	logic [INDEX_BITS:0]   bump_count;
	logic [INDEX_BITS:0]   node_cap;

	grant_t                owed [$];        // results still to arrive, oldest first
	grant_t                step_res [$];    // results of the last accepted request
	logic [INDEX_BITS-1:0] held_nodes [$];  // indices handed out and not yet freed

	int  mismatches;
	int  stall_cnt;
	int  hold_asked;
	int  hold_given;
	bit  idle_on;

	batch_index_allocator #(
		.INDEX_BITS(INDEX_BITS),
		.MAX_BATCH (MAX_BATCH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Clock
	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Model: emit one result into the step list
	function automatic void emit(input logic [INDEX_BITS-1:0] node,
			input logic [STATUS_W-1:0] status, input logic valid, input logic last);
		grant_t g;
		g.node   = node;
		g.status = status;
		g.valid  = valid;
		g.last   = last;
		step_res.push_back(g);
	endfunction

	function automatic void push_free(input logic [INDEX_BITS-1:0] node);
		if (lifo_depth < POOL) begin
			free_lifo[lifo_depth[INDEX_BITS-1:0]] = node;
			lifo_depth++;
		end
	endfunction

	// Model: apply one accepted request, results land in step_res
	function automatic void apply_request(input logic [MODE_W-1:0] mode,
			input logic [COUNT_W-1:0] cnt, input logic [INDEX_BITS-1:0] node);
		logic [INDEX_BITS-1:0] taken [MAX_BATCH];
		logic [INDEX_BITS:0]   limit;
		int want, i, j;
		bit fail;
		step_res.delete();
		case (mode)
			MODE_ALLOC: begin
				limit = (node_cap > POOL) ? POOL[INDEX_BITS:0] : node_cap;
				want  = (cnt > MAX_BATCH) ? MAX_BATCH : int'(cnt);
				i     = 0;
				fail  = 1'b0;
				if (want != 0) begin
					// stack first
					while (lifo_depth != 0 && i < want) begin
						lifo_depth--;
						taken[i] = free_lifo[lifo_depth[INDEX_BITS-1:0]];
						i++;
					end
					// then bump until the cap
					while (i < want && !fail) begin
						if (bump_count >= limit) begin
							fail = 1'b1;
						end else begin
							taken[i] = bump_count[INDEX_BITS-1:0];
							bump_count++;
							i++;
						end
					end
					if (fail) begin
						// roll back in the order taken
						for (j = 0; j < i; j++)
							push_free(taken[j]);
						emit('0, ST_NO_MEM, 1'b0, 1'b1);
					end else begin
						for (j = 0; j < want; j++) begin
							emit(taken[j], ST_OK, 1'b0, j == want - 1);
							held_nodes.push_back(taken[j]);
						end
					end
				end
			end
			MODE_FREE: begin
				if (node >= bump_count || lifo_depth >= bump_count) begin
					emit('0, ST_REJECT, 1'b0, 1'b1);
				end else begin
					push_free(node);
					emit('0, ST_OK, 1'b0, 1'b1);
				end
			end
			MODE_CHECK: begin
				emit('0, ST_OK, node < bump_count, 1'b1);
			end
			default: ;
		endcase
	endfunction

	// Offer one request and hold it until the transfer; valid stays high on return
	task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] cnt,
			input logic [INDEX_BITS-1:0] node);
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= {node, cnt};
		do @(posedge clk); while (!s_tready);
		apply_request(mode, cnt, node);
	endtask

	// Random sender gap
	task automatic maybe_pause();
		if (idle_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// Wait until every result is in, then let the sequencer go quiet
	task automatic drain();
		s_tvalid <= 1'b0;
		while (owed.size() != 0)
			@(posedge clk);
		repeat (TAIL) @(posedge clk);
	endtask

	task automatic write_cap(input logic [INDEX_BITS:0] value);
		cfg_data  <= value;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		node_cap = value;
		cfg_valid <= 1'b0;
	endtask

	// Random request; frees mostly name indices actually held
	task automatic issue_random_request();
		logic [MODE_W-1:0]     mode;
		logic [COUNT_W-1:0]    cnt;
		logic [INDEX_BITS-1:0] node;
		int pick, k;
		pick = $urandom_range(0, 99);
		cnt  = COUNT_W'($urandom_range(1, MAX_BATCH));
		node = INDEX_BITS'($urandom);
		if (pick < 40) begin
			mode = MODE_ALLOC;
			if ($urandom_range(0, 9) == 0)
				cnt = COUNT_W'($urandom_range(0, 15));
		end else if (pick < 75) begin
			mode = MODE_FREE;
			k = $urandom_range(0, 99);
			cnt = COUNT_W'($urandom);
			if (k < 70 && held_nodes.size() != 0) begin
				k = $urandom_range(0, held_nodes.size() - 1);
				node = held_nodes[k];
				held_nodes.delete(k);
			end else if (k < 85 && bump_count != 0) begin
				node = INDEX_BITS'($urandom_range(0, int'(bump_count) - 1));
			end
		end else if (pick < 95) begin
			mode = MODE_CHECK;
			cnt = COUNT_W'($urandom);
			if ($urandom_range(0, 1) == 0)
				node = INDEX_BITS'($urandom_range(0, int'(bump_count) + 3));
		end else begin
			mode = MODE_NONE;
			cnt = COUNT_W'($urandom);
		end
		send_item(mode, cnt, node);
	endtask

	// Stimulus
	initial begin
		int r, p, n_done, k;
		grant_t g;
		clk       = 1'b0;
		arst_n    = 1'b0;
		cfg_valid = 1'b0;
		cfg_data  = '0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = '0;
		mismatches = 0;
		hold_asked = 0;
		idle_on    = 1'b1;
		lifo_depth = '0;
		bump_count = '0;
		node_cap   = (INDEX_BITS+1)'(MAX_NODES_RESET);
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table
		for (r = 0; r < DIR_N; r++) begin
			send_item(dir_rows[r].mode, dir_rows[r].cnt, dir_rows[r].node);
			if (dir_rows[r].typed) begin
				g.node   = dir_rows[r].t_node;
				g.status = dir_rows[r].t_status;
				g.valid  = dir_rows[r].t_valid;
				g.last   = 1'b1;
				owed.push_back(g);
			end else begin
				for (k = 0; k < step_res.size(); k++)
					owed.push_back(step_res[k]);
			end
			maybe_pause();
		end

		// random phases, one cap setting each
		for (p = 0; p < N_PHASES; p++) begin
			drain();
			idle_on = (p != N_PHASES - 1);
			write_cap(phase_caps[p]);
			if (p == 0)
				hold_asked++;
			n_done = 0;
			while (n_done < RAND_PER_PHASE) begin
				issue_random_request();
				for (k = 0; k < step_res.size(); k++)
					owed.push_back(step_res[k]);
				if (step_res.size() != 0)
					n_done++;
				maybe_pause();
			end
		end
		drain();

		if (mismatches == 0 && owed.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Receiver: random bursts of backpressure, plus one long hold-off
	initial begin
		m_tready   = 1'b0;
		hold_given = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_given < hold_asked) begin
				hold_given++;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				m_tready <= 1'b1;
			end else if (idle_on && $urandom_range(0, 4) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 5)) @(posedge clk);
				m_tready <= 1'b1;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Result checker
	always @(posedge clk) begin
		grant_t e;
		if (arst_n && m_tvalid && m_tready) begin
			if (owed.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: node=%0d status=%0d valid=%0d last=%0d",
						m_tdata[INDEX_BITS-1:0], m_tuser, m_tdata[INDEX_BITS], m_tlast);
			end else begin
				e = owed.pop_front();
				if (m_tdata[INDEX_BITS-1:0] !== e.node || m_tuser !== e.status ||
						m_tdata[INDEX_BITS] !== e.valid || m_tlast !== e.last) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp node=%0d status=%0d valid=%0d last=%0d,",
							e.node, e.status, e.valid, e.last,
							" got node=%0d status=%0d valid=%0d last=%0d",
							m_tdata[INDEX_BITS-1:0], m_tuser, m_tdata[INDEX_BITS],
							m_tlast);
				end
			end
		end
	end

	// Watchdog: cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

endmodule

// ----- files.f -----
hw/rtl/bia_pkg.sv
hw/rtl/bia_stack_ram.sv
hw/rtl/bia_seq.sv
hw/rtl/batch_index_allocator.sv
dv/tb_batch_index_allocator.sv
